// ===== sv/tms_pkg.sv =====
// Shared types, codes and constants of the Turing machine stepper with video tap.
// Used by every module of the block; depends on nothing.
package tms_pkg;

  localparam int STATE_BITS      = 14;
  localparam int TAPE_ADDR_BITS  = 19;
  localparam int SYMBOL_COUNT    = 4;
  localparam int SYMBOL_BITS     = $clog2(SYMBOL_COUNT);
  localparam int RULE_ADDR_BITS  = STATE_BITS + SYMBOL_BITS;
  localparam int CFG_DATA_BITS   = (STATE_BITS > TAPE_ADDR_BITS) ? STATE_BITS : TAPE_ADDR_BITS;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int GATHER_CELLS    = 24;
  localparam int GATHER_CNT_BITS = $clog2(GATHER_CELLS);

  // Tape cell value that reads as a one bit during the gather.
  localparam logic [SYMBOL_BITS-1:0] SYM_ONE = SYMBOL_BITS'(2);

  localparam logic [STATE_BITS-1:0]     VIDEO_STATE_RESET = STATE_BITS'(7477);
  localparam logic [TAPE_ADDR_BITS-1:0] DATA_BASE_RESET   = TAPE_ADDR_BITS'(141);
  localparam logic [TAPE_ADDR_BITS-1:0] ADDR_LO_RESET     = TAPE_ADDR_BITS'(150);
  localparam logic [TAPE_ADDR_BITS-1:0] ADDR_HI_RESET     = TAPE_ADDR_BITS'(159);

  localparam logic [15:0] HIRES_PAGE_MASK = 16'hE000;
  localparam logic [15:0] HIRES_PAGE      = 16'h2000;
  localparam logic [6:0]  LAST_BYTE_LOW7  = 7'd119;
  localparam logic [6:0]  LINE_BYTES      = 7'd40;

  typedef enum logic [1:0] {
    FUNC_LOAD_RULE  = 2'd0,
    FUNC_WRITE_CELL = 2'd1,
    FUNC_STEP       = 2'd2,
    FUNC_READ_CELL  = 2'd3
  } func_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_VIDEO_STATE = 2'd0,
    CFG_DATA_BASE   = 2'd1,
    CFG_ADDR_LOW    = 2'd2,
    CFG_ADDR_HIGH   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_VIDEO = 1'b0,
    KIND_READ  = 1'b1
  } rsp_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SYM,
    S_RULE,
    S_READ,
    S_GATHER,
    S_FLUSH,
    S_DECIDE
  } seq_state_e;

  typedef struct packed {
    func_e                     func;
    logic [STATE_BITS-1:0]     rule_state;
    logic [SYMBOL_BITS-1:0]    rule_symbol;
    logic [STATE_BITS-1:0]     next_state;
    logic [SYMBOL_BITS-1:0]    symbol_value;
    logic                      move_left;
    logic [TAPE_ADDR_BITS-1:0] cell_address;
  } req_t;

  typedef struct packed {
    rsp_kind_e              kind;
    logic [5:0]             column;
    logic [7:0]             line;
    logic [6:0]             pixels;
    logic [SYMBOL_BITS-1:0] read_symbol;
  } rsp_t;

  typedef struct packed {
    logic                   move_left;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [STATE_BITS-1:0]  next_state;
  } rule_t;

  typedef struct packed {
    logic                      en;
    logic                      we;
    logic [TAPE_ADDR_BITS-1:0] addr;
    logic [SYMBOL_BITS-1:0]    wdata;
  } tape_cmd_t;

  typedef struct packed {
    logic                      en;
    logic                      we;
    logic [RULE_ADDR_BITS-1:0] addr;
    rule_t                     wdata;
  } rule_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] column;
    logic [7:0] line;
    logic [6:0] pixels;
  } video_t;

  // bits = {data, address high, address low}, each most significant bit first.
  function automatic video_t video_map(input logic [23:0] bits);
    logic [15:0] addr;
    logic [6:0]  low7;
    logic [6:0]  col;
    logic [1:0]  third;
    video_t      v;
    addr = bits[15:0];
    low7 = addr[6:0];
    if (low7 >= 7'(2 * LINE_BYTES)) begin
      third = 2'd2;
      col   = low7 - 7'(2 * LINE_BYTES);
    end else if (low7 >= LINE_BYTES) begin
      third = 2'd1;
      col   = low7 - LINE_BYTES;
    end else begin
      third = 2'd0;
      col   = low7;
    end
    v.hit    = ((addr & HIRES_PAGE_MASK) == HIRES_PAGE) && (low7 <= LAST_BYTE_LOW7);
    v.column = col[5:0];
    // third*64 + addr[9:7]*8 + addr[12:10]: the fields do not overlap
    v.line   = {third, addr[9:7], addr[12:10]};
    v.pixels = bits[22:16];
    return v;
  endfunction

endpackage

// ===== sv/tms_tape.sv =====
// Tape store: one 2-bit cell per tape position, single port, registered read.
// Depends on tms_pkg.
module tms_tape (
  input  logic                                clk,
  input  tms_pkg::tape_cmd_t                  cmd,
  output logic [tms_pkg::SYMBOL_BITS-1:0]     rdata
);
  import tms_pkg::*;

  localparam int DEPTH = 1 << TAPE_ADDR_BITS;

  logic [SYMBOL_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[cmd.addr] <= cmd.wdata;
      end else begin
        rdata <= mem[cmd.addr];
      end
    end
  end

endmodule

// ===== sv/tms_rules.sv =====
// Rule store indexed by {state, symbol}, single port, registered read.
// Depends on tms_pkg.
module tms_rules (
  input  logic               clk,
  input  tms_pkg::rule_cmd_t cmd,
  output tms_pkg::rule_t     rdata
);
  import tms_pkg::*;

  localparam int DEPTH = 1 << RULE_ADDR_BITS;

  rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[cmd.addr] <= cmd.wdata;
      end else begin
        rdata <= mem[cmd.addr];
      end
    end
  end

endmodule

// ===== sv/tms_gather.sv =====
// Gather shift register for the 24 tape bits of a video write, plus its decode.
// Depends on tms_pkg.
module tms_gather (
  input  logic            clk,
  input  logic            shift_en,
  input  logic            shift_bit,
  output tms_pkg::video_t vid
);
  import tms_pkg::*;

  logic [GATHER_CELLS-1:0] bits;

  // shift in most significant bit first
  always_ff @(posedge clk) begin
    if (shift_en) begin
      bits <= {bits[GATHER_CELLS-2:0], shift_bit};
    end
  end

  assign vid = video_map(bits);

endmodule

// ===== sv/turing_machine_stepper_with_video_tap_core.sv =====
// Top level of the Turing machine stepper with video tap: sequencer, shared adder,
// configuration registers and output register. Depends on tms_pkg, tms_tape,
// tms_rules and tms_gather.
//
// A request either loads a rule, writes a tape cell, reads a tape cell or runs one
// machine step. Requests are taken one at a time; the block stalls its input until
// the current request is finished. Load rule and write cell finish in the decode
// state; read cell reads the tape, then waits while the output register is full.
// A step reads the tape, then reads the rule, then writes the tape and moves the
// head. A step that lands in the configured video state then gathers 24 tape cells
// through the single tape port, one per cycle, and decodes them; a hit waits while
// the output register is full. The tape port and the one adder (head move and
// gather cell address) are the shared resources of the block. Finished responses
// sit in an output register, so a new request is taken while a response still
// waits. Tape and rule memories come up undefined; read only what was written.
// Write configuration only while the block is idle.
module turing_machine_stepper_with_video_tap_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  tms_pkg::cfg_reg_e                     cfg_index,
  input  logic [tms_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  tms_pkg::req_t                         req_data,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output tms_pkg::rsp_t                         rsp_data
);
  import tms_pkg::*;

  localparam logic [1:0] GRP_DATA    = 2'd0;
  localparam logic [1:0] GRP_ADDR_HI = 2'd1;
  localparam logic [1:0] GRP_ADDR_LO = 2'd2;
  localparam logic [GATHER_CNT_BITS-1:0] GATHER_LAST = GATHER_CNT_BITS'(GATHER_CELLS - 1);

  // Configuration
  logic [STATE_BITS-1:0]     video_state;
  logic [TAPE_ADDR_BITS-1:0] data_base;
  logic [TAPE_ADDR_BITS-1:0] addr_lo_base;
  logic [TAPE_ADDR_BITS-1:0] addr_hi_base;

  // Machine and sequencer state
  seq_state_e                 state, state_next;
  req_t                       req;
  logic [STATE_BITS-1:0]      cur_state;
  logic [TAPE_ADDR_BITS-1:0]  head;
  logic [GATHER_CNT_BITS-1:0] gcnt;
  logic                       capture;

  // Memory ports and shared adder
  tape_cmd_t                 tape_cmd;
  logic [SYMBOL_BITS-1:0]    tape_q;
  rule_cmd_t                 rule_cmd;
  rule_t                     rule_q;
  logic [TAPE_ADDR_BITS-1:0] add_a, add_b, add_sum;
  video_t                    vid;

  logic out_free;
  logic load_rsp;
  rsp_t rsp_next;
  logic req_fire;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign add_sum   = add_a + add_b;

  tms_tape u_tape (
    .clk   (clk),
    .cmd   (tape_cmd),
    .rdata (tape_q)
  );

  tms_rules u_rules (
    .clk   (clk),
    .cmd   (rule_cmd),
    .rdata (rule_q)
  );

  tms_gather u_gather (
    .clk       (clk),
    .shift_en  (capture),
    .shift_bit (tape_q == SYM_ONE),
    .vid       (vid)
  );

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (req.func)
          FUNC_STEP:      state_next = S_SYM;
          FUNC_READ_CELL: state_next = S_READ;
          default:        state_next = S_IDLE;
        endcase
      end
      S_SYM:  state_next = S_RULE;
      S_RULE: begin
        // gather whenever the step ends in the video state, even if it stayed there
        state_next = (rule_q.next_state == video_state) ? S_GATHER : S_IDLE;
      end
      S_READ: begin
        if (out_free) state_next = S_IDLE;
      end
      S_GATHER: begin
        if (gcnt == GATHER_LAST) state_next = S_FLUSH;
      end
      S_FLUSH:  state_next = S_DECIDE;
      S_DECIDE: begin
        if (!vid.hit || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory commands, adder operands and response load
  always_comb begin
    tape_cmd = '0;
    rule_cmd = '0;
    add_a    = head;
    add_b    = '0;
    load_rsp = 1'b0;
    rsp_next = '0;
    case (state)
      S_DECODE: begin
        case (req.func)
          FUNC_LOAD_RULE: begin
            rule_cmd.en               = 1'b1;
            rule_cmd.we               = 1'b1;
            rule_cmd.addr             = {req.rule_state, req.rule_symbol};
            rule_cmd.wdata.move_left  = req.move_left;
            rule_cmd.wdata.symbol     = req.symbol_value;
            rule_cmd.wdata.next_state = req.next_state;
          end
          FUNC_WRITE_CELL: begin
            tape_cmd.en    = 1'b1;
            tape_cmd.we    = 1'b1;
            tape_cmd.addr  = req.cell_address;
            tape_cmd.wdata = req.symbol_value;
          end
          FUNC_STEP: begin
            // read the cell under the head
            tape_cmd.en   = 1'b1;
            tape_cmd.addr = head;
          end
          default: begin
            tape_cmd.en   = 1'b1;
            tape_cmd.addr = req.cell_address;
          end
        endcase
      end
      S_SYM: begin
        rule_cmd.en   = 1'b1;
        rule_cmd.addr = {cur_state, tape_q};
      end
      S_RULE: begin
        // write the rule's symbol back and move the head, wrapping at the tape size
        tape_cmd.en    = 1'b1;
        tape_cmd.we    = 1'b1;
        tape_cmd.addr  = head;
        tape_cmd.wdata = rule_q.symbol;
        add_b          = rule_q.move_left ? '1 : TAPE_ADDR_BITS'(1);
      end
      S_READ: begin
        load_rsp             = out_free;
        rsp_next.kind        = KIND_READ;
        rsp_next.read_symbol = tape_q;
      end
      S_GATHER: begin
        // cell = base + bit index; data, then address high, then address low
        case (gcnt[4:3])
          GRP_DATA:    add_a = data_base;
          GRP_ADDR_HI: add_a = addr_hi_base;
          GRP_ADDR_LO: add_a = addr_lo_base;
          default:     add_a = data_base;
        endcase
        add_b         = TAPE_ADDR_BITS'(gcnt[2:0]);
        tape_cmd.en   = 1'b1;
        tape_cmd.addr = add_sum;
      end
      S_DECIDE: begin
        load_rsp        = vid.hit && out_free;
        rsp_next.kind   = KIND_VIDEO;
        rsp_next.column = vid.column;
        rsp_next.line   = vid.line;
        rsp_next.pixels = vid.pixels;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_state    <= '0;
      head         <= '0;
      capture      <= 1'b0;
      rsp_valid    <= 1'b0;
      video_state  <= VIDEO_STATE_RESET;
      data_base    <= DATA_BASE_RESET;
      addr_lo_base <= ADDR_LO_RESET;
      addr_hi_base <= ADDR_HI_RESET;
    end else begin
      state   <= state_next;
      capture <= (state == S_GATHER);
      if (state == S_RULE) begin
        head      <= add_sum;
        cur_state <= rule_q.next_state;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_VIDEO_STATE: video_state  <= cfg_data[STATE_BITS-1:0];
          CFG_DATA_BASE:   data_base    <= cfg_data[TAPE_ADDR_BITS-1:0];
          CFG_ADDR_LOW:    addr_lo_base <= cfg_data[TAPE_ADDR_BITS-1:0];
          CFG_ADDR_HIGH:   addr_hi_base <= cfg_data[TAPE_ADDR_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_fire) req <= req_data;
    if (load_rsp) rsp_data <= rsp_next;
    if (state == S_RULE) begin
      gcnt <= '0;
    end else if (state == S_GATHER) begin
      gcnt <= gcnt + GATHER_CNT_BITS'(1);
    end
  end

  // A step moves the head by exactly one cell, wrapping at the tape size.
  a_head_moves_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_RULE) |=>
      (head == TAPE_ADDR_BITS'($past(head) + TAPE_ADDR_BITS'(1))) ||
      (head == TAPE_ADDR_BITS'($past(head) - TAPE_ADDR_BITS'(1))))
    else $error("head did not move by one cell on a step");

  // A step that does not land in the video state finishes without a gather.
  a_no_gather: assert property (@(posedge clk) disable iff (rst)
    (state == S_RULE && rule_q.next_state != video_state) |=> (state == S_IDLE))
    else $error("step outside the video state did not finish");

  // The gather index never runs past the last cell.
  a_gcnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_GATHER) |-> (gcnt <= GATHER_LAST))
    else $error("gather index out of range");

  // A response appears only from a read answer or a decided video write.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_READ || $past(state) == S_DECIDE))
    else $error("response loaded from an unexpected state");

endmodule

// ===== sim/tb_turing_machine_stepper_with_video_tap_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for turing_machine_stepper_with_video_tap_core.
// Depends on tms_pkg and the core; carries its own model of the machine, tape and video tap.
module tb_turing_machine_stepper_with_video_tap_core;
  import tms_pkg::*;

  // Cycles to wait after the last answer before touching configuration or ending:
  // a step into the video state runs a full gather and may end with no answer.
  localparam int DRAIN_CYCLES  = 40;
  localparam int PHASE_ITEMS   = 300;
  localparam int PHASE_COUNT   = 6;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_LIGHT,
    DRAIN_HEAVY,
    DRAIN_HOLD
  } stall_mode_e;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  cfg_reg_e                  cfg_index = CFG_VIDEO_STATE;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  req_t                      req_data = '0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  rsp_t                      rsp_data;

  turing_machine_stepper_with_video_tap_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest legal run is a few ms, so this only trips on a hang.
  initial begin
    #(20_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Machine model. Tape and rule entries exist in the maps only once written,
  // which also lets the stimulus avoid reading anything that was never written.
  // ---------------------------------------------------------------------------
  logic [SYMBOL_BITS-1:0]    tape_cells [int];
  rule_t                     rule_book [int];
  int                        written_cells [$];
  logic [STATE_BITS-1:0]     cur_state;
  logic [TAPE_ADDR_BITS-1:0] head_pos;
  logic [STATE_BITS-1:0]     video_state;
  logic [TAPE_ADDR_BITS-1:0] data_base;
  logic [TAPE_ADDR_BITS-1:0] addr_lo_base;
  logic [TAPE_ADDR_BITS-1:0] addr_hi_base;

  rsp_t                      due_answers [$];
  int                        mismatch_count = 0;
  int                        sent_count = 0;
  int                        burst_left = 0;
  logic [STATE_BITS-1:0]     state_pool [8];

  stall_mode_e               stall_mode = DRAIN_FREE;
  int                        stall_mode_left = 0;

  function automatic int rule_key(input logic [STATE_BITS-1:0] st,
                                  input logic [SYMBOL_BITS-1:0] sy);
    return int'({st, sy});
  endfunction

  // Eight cells from base upward (wrapping at the tape end), first cell is the MSB.
  function automatic logic [7:0] gather_byte(input logic [TAPE_ADDR_BITS-1:0] base);
    logic [7:0]                b;
    logic [TAPE_ADDR_BITS-1:0] c;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      c = base + TAPE_ADDR_BITS'(i);
      if (tape_cells[int'(c)] == SYM_ONE) b[7-i] = 1'b1;
    end
    return b;
  endfunction

  // Apply one accepted request to the model and queue the answer it owes, if any.
  function automatic void advance_machine(input req_t r);
    rule_t                  rl;
    logic [SYMBOL_BITS-1:0] sy;
    logic [7:0]             data_b;
    logic [15:0]            vaddr;
    logic [6:0]             low7;
    rsp_t                   ans;
    ans = '0;
    case (r.func)
      FUNC_LOAD_RULE: begin
        rl.next_state = r.next_state;
        rl.symbol     = r.symbol_value;
        rl.move_left  = r.move_left;
        rule_book[rule_key(r.rule_state, r.rule_symbol)] = rl;
      end
      FUNC_WRITE_CELL: begin
        if (!tape_cells.exists(int'(r.cell_address))) written_cells.push_back(int'(r.cell_address));
        tape_cells[int'(r.cell_address)] = r.symbol_value;
      end
      FUNC_READ_CELL: begin
        ans.kind        = KIND_READ;
        ans.read_symbol = tape_cells[int'(r.cell_address)];
        due_answers.push_back(ans);
      end
      default: begin
        sy = tape_cells[int'(head_pos)];
        rl = rule_book[rule_key(cur_state, sy)];
        tape_cells[int'(head_pos)] = rl.symbol;
        head_pos  = rl.move_left ? head_pos - 1'b1 : head_pos + 1'b1;
        cur_state = rl.next_state;
        // Landing in the video state (also by staying in it) triggers the gather.
        if (cur_state == video_state) begin
          data_b = gather_byte(data_base);
          vaddr  = {gather_byte(addr_hi_base), gather_byte(addr_lo_base)};
          low7   = vaddr[6:0];
          if ((vaddr & HIRES_PAGE_MASK) == HIRES_PAGE && low7 <= LAST_BYTE_LOW7) begin
            ans.kind   = KIND_VIDEO;
            ans.column = 6'(int'(low7) % 40);
            ans.line   = 8'((int'(low7) / 40) * 64 + int'(vaddr[9:7]) * 8
                            + int'(vaddr[12:10]));
            ans.pixels = data_b[6:0];
            due_answers.push_back(ans);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Answer side: stall on a pattern of its own, check every accepted answer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = (stall_mode == DRAIN_HOLD) ? $urandom_range(5, 40)
                                                   : $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      DRAIN_FREE:  rsp_stall <= 1'b0;
      DRAIN_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      DRAIN_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
      default:     rsp_stall <= 1'b1;
    endcase
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_answers.size() == 0) begin
        $error("answer with nothing outstanding: kind %0d", rsp_data.kind);
        mismatch_count++;
      end else begin
        want = due_answers.pop_front();
        check_field("kind",        want.kind,        rsp_data.kind);
        check_field("column",      want.column,      rsp_data.column);
        check_field("line",        want.line,        rsp_data.line);
        check_field("pixels",      want.pixels,      rsp_data.pixels);
        check_field("read_symbol", want.read_symbol, rsp_data.read_symbol);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. All tasks are entered and left right at a rising edge.
  // ---------------------------------------------------------------------------

  // Send one request in bursts of random length with random gaps between them.
  // Valid stays up across back-to-back requests; drop it only for a gap.
  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    advance_machine(r);
    sent_count++;
  endtask

  // Unused fields of every request carry random bits.
  function automatic req_t noise_req(input func_e f);
    logic [63:0] bits;
    req_t        r;
    bits   = {$urandom, $urandom};
    r      = bits[$bits(req_t)-1:0];
    r.func = f;
    return r;
  endfunction

  task automatic write_cell(input logic [TAPE_ADDR_BITS-1:0] addr,
                            input logic [SYMBOL_BITS-1:0] value);
    req_t r;
    r              = noise_req(FUNC_WRITE_CELL);
    r.cell_address = addr;
    r.symbol_value = value;
    send_req(r);
  endtask

  task automatic read_cell(input logic [TAPE_ADDR_BITS-1:0] addr);
    req_t r;
    r              = noise_req(FUNC_READ_CELL);
    r.cell_address = addr;
    send_req(r);
  endtask

  task automatic load_rule(input logic [STATE_BITS-1:0] st, input logic [SYMBOL_BITS-1:0] sy,
                           input logic [STATE_BITS-1:0] nx, input logic [SYMBOL_BITS-1:0] ws,
                           input logic left);
    req_t r;
    r              = noise_req(FUNC_LOAD_RULE);
    r.rule_state   = st;
    r.rule_symbol  = sy;
    r.next_state   = nx;
    r.symbol_value = ws;
    r.move_left    = left;
    send_req(r);
  endtask

  // Write all four registers back to back, then drop the enable once.
  task automatic configure(input logic [CFG_DATA_BITS-1:0] vs_raw,
                           input logic [TAPE_ADDR_BITS-1:0] db,
                           input logic [TAPE_ADDR_BITS-1:0] lo,
                           input logic [TAPE_ADDR_BITS-1:0] hi);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_VIDEO_STATE;
    cfg_data  <= vs_raw;
    @(posedge clk);
    cfg_index <= CFG_DATA_BASE;
    cfg_data  <= CFG_DATA_BITS'(db);
    @(posedge clk);
    cfg_index <= CFG_ADDR_LOW;
    cfg_data  <= CFG_DATA_BITS'(lo);
    @(posedge clk);
    cfg_index <= CFG_ADDR_HIGH;
    cfg_data  <= CFG_DATA_BITS'(hi);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    video_state  = vs_raw[STATE_BITS-1:0];
    data_base    = db;
    addr_lo_base = lo;
    addr_hi_base = hi;
  endtask

  // Hold off until every answer is in, then let a possible silent step finish.
  task automatic wait_idle();
    req_valid <= 1'b0;
    for (int n = 0; n < 20000 && due_answers.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SYMBOL_BITS-1:0] zero_symbol();
    logic [SYMBOL_BITS-1:0] s;
    s = SYMBOL_BITS'($urandom_range(0, 2));
    if (s == SYM_ONE) s = 2'd3;
    return s;
  endfunction

  task automatic plant_byte(input logic [TAPE_ADDR_BITS-1:0] base, input logic [7:0] value);
    for (int i = 0; i < 8; i++)
      write_cell(base + TAPE_ADDR_BITS'(i), value[7-i] ? SYM_ONE : zero_symbol());
  endtask

  // Lay a data byte and an address on the tape; off-page or past-119 when not good.
  task automatic plant_video_word(input bit good);
    logic [15:0] vaddr;
    int          top;
    vaddr = 16'($urandom);
    if (good) begin
      vaddr[15:13] = 3'b001;
      vaddr[6:0]   = 7'($urandom_range(0, 119));
    end else if ($urandom_range(0, 1) == 0) begin
      top = $urandom_range(0, 6);
      if (top >= 1) top++;
      vaddr[15:13] = 3'(top);
    end else begin
      vaddr[15:13] = 3'b001;
      vaddr[6:0]   = 7'($urandom_range(120, 127));
    end
    plant_byte(data_base, 8'($urandom));
    plant_byte(addr_lo_base, vaddr[7:0]);
    plant_byte(addr_hi_base, vaddr[15:8]);
  endtask

  // Write any gather cell that is still blank so a step into the video state is legal.
  task automatic fill_gather_gaps();
    logic [TAPE_ADDR_BITS-1:0] bases [3];
    logic [TAPE_ADDR_BITS-1:0] c;
    bases = '{data_base, addr_lo_base, addr_hi_base};
    for (int b = 0; b < 3; b++)
      for (int i = 0; i < 8; i++) begin
        c = bases[b] + TAPE_ADDR_BITS'(i);
        if (!tape_cells.exists(int'(c)))
          write_cell(c, ($urandom_range(0, 1) == 0) ? SYM_ONE : zero_symbol());
      end
  endtask

  function automatic logic [STATE_BITS-1:0] pick_next_state();
    if ($urandom_range(0, 99) < 35) return video_state;
    return state_pool[$urandom_range(0, 7)];
  endfunction

  // One step, with whatever tape cell and rule it needs written first.
  // A forced rule replaces the one under (state, symbol) when given.
  task automatic machine_step(input bit force_rule, input logic [STATE_BITS-1:0] nx,
                              input logic [SYMBOL_BITS-1:0] ws, input logic left);
    logic [SYMBOL_BITS-1:0] sy;
    rule_t                  rl;
    if (!tape_cells.exists(int'(head_pos))) write_cell(head_pos, SYMBOL_BITS'($urandom));
    sy = tape_cells[int'(head_pos)];
    if (force_rule)
      load_rule(cur_state, sy, nx, ws, left);
    else if (!rule_book.exists(rule_key(cur_state, sy)))
      load_rule(cur_state, sy, pick_next_state(), SYMBOL_BITS'($urandom), 1'($urandom));
    rl = rule_book[rule_key(cur_state, sy)];
    if (rl.next_state == video_state) fill_gather_gaps();
    send_req(noise_req(FUNC_STEP));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Tape extremes, every request type, head wrap in both directions.
  task automatic test_access_and_wrap();
    write_cell('0, 2'd3);
    write_cell('1, SYM_ONE);
    read_cell('1);
    read_cell('0);
    // state 0 reads 3 at cell 0, moves left: head wraps to the last cell
    load_rule('0, 2'd3, '1, 2'd1, 1'b1);
    send_req(noise_req(FUNC_STEP));
    // top state reads 2 at the last cell, moves right: head wraps to cell 0
    load_rule('1, SYM_ONE, '0, 2'd0, 1'b0);
    send_req(noise_req(FUNC_STEP));
    read_cell('1);
    read_cell('0);
    write_cell(TAPE_ADDR_BITS'(19'h2AAAA), 2'd1);
    read_cell(TAPE_ADDR_BITS'(19'h2AAAA));
  endtask

  // All three words from one byte of cells that wraps at the tape end; enter the
  // video state, stay in it, then move the address off the hi-res page.
  task automatic test_video_shared_base();
    wait_idle();
    // upper data bits set on the state register: only the low bits count
    configure('1, TAPE_ADDR_BITS'(19'h7FFFB), TAPE_ADDR_BITS'(19'h7FFFB),
              TAPE_ADDR_BITS'(19'h7FFFB));
    plant_byte(TAPE_ADDR_BITS'(19'h7FFFB), 8'h3A);
    // head walks right over cells 0 and 1, rewriting them with what they already mean
    machine_step(1'b1, '1, 2'd1, 1'b0);
    machine_step(1'b1, '1, SYM_ONE, 1'b0);
    plant_byte(TAPE_ADDR_BITS'(19'h7FFFB), 8'h5A);
    machine_step(1'b1, '1, 2'd0, 1'b0);
  endtask

  // Phases of mostly well-formed machine traffic, each under its own settings.
  task automatic test_random_traffic();
    int                        start;
    int                        pick;
    logic [TAPE_ADDR_BITS-1:0] db;
    logic [TAPE_ADDR_BITS-1:0] lo;
    state_pool[0] = '0;
    state_pool[1] = '1;
    for (int i = 2; i < 8; i++) state_pool[i] = STATE_BITS'($urandom);
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: configure(CFG_DATA_BITS'(VIDEO_STATE_RESET), DATA_BASE_RESET, ADDR_LO_RESET,
                     ADDR_HI_RESET);
        1: configure('0, '0, TAPE_ADDR_BITS'(8), TAPE_ADDR_BITS'(16));
        // gather runs across the tape end
        2: configure('1, '1, TAPE_ADDR_BITS'(19'h7FFEF), TAPE_ADDR_BITS'(19'h7FFF7));
        default: begin
          db = TAPE_ADDR_BITS'($urandom);
          lo = db + TAPE_ADDR_BITS'(8 + $urandom_range(0, 4));
          configure(CFG_DATA_BITS'($urandom), db, lo,
                    lo + TAPE_ADDR_BITS'(8 + $urandom_range(0, 4)));
        end
      endcase
      plant_video_word(1'b1);
      start = sent_count;
      while (sent_count - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          machine_step(1'b0, '0, '0, 1'b0);
        else if (pick < 49)
          plant_video_word($urandom_range(0, 3) != 0);
        else if (pick < 55)
          plant_byte(data_base, 8'($urandom));
        else if (pick < 65)
          write_cell(TAPE_ADDR_BITS'($urandom), SYMBOL_BITS'($urandom));
        else if (pick < 72)
          write_cell(head_pos + TAPE_ADDR_BITS'($urandom_range(0, 8)) - TAPE_ADDR_BITS'(4),
                     SYMBOL_BITS'($urandom));
        else if (pick < 84)
          read_cell(TAPE_ADDR_BITS'(written_cells[$urandom_range(0, written_cells.size() - 1)]));
        else if (pick < 92)
          load_rule(STATE_BITS'($urandom), SYMBOL_BITS'($urandom), STATE_BITS'($urandom),
                    SYMBOL_BITS'($urandom), 1'($urandom));
        else
          // rule that can throw the machine into an arbitrary state; steps load missing rules
          load_rule(cur_state, SYMBOL_BITS'($urandom), STATE_BITS'($urandom),
                    SYMBOL_BITS'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    cur_state    = '0;
    head_pos     = '0;
    video_state  = VIDEO_STATE_RESET;
    data_base    = DATA_BASE_RESET;
    addr_lo_base = ADDR_LO_RESET;
    addr_hi_base = ADDR_HI_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_access_and_wrap();
    test_video_shared_base();
    test_random_traffic();

    wait_idle();
    if (due_answers.size() != 0) begin
      $error("%0d expected answers never arrived", due_answers.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
